// ===== rtl/hwl_pkg.sv =====
// ============================================================================
// hwl_pkg: shared types and constants for the homography warp lookup
// Coefficient layout, register map codes and datapath widths.
// ============================================================================
package hwl_pkg;

	localparam int MAX_DIM        = 4096;
	localparam int COEF_BITS      = 21;
	localparam int COEF_FRAC_BITS = 16;
	localparam int DIM_W          = 13;   // out_width / out_height register
	localparam int PIX_W          = 12;   // pixel coordinate and W-1 / H-1
	localparam int ROW_W          = 3 * COEF_BITS;
	localparam int PROD_W         = 2 * PIX_W;   // pixel * dim product
	localparam int ACC_W          = 48;          // homogeneous component
	localparam int RES_W          = 16;
	localparam int DIV_STEPS      = 16;
	localparam int CFG_DATA_W     = 64;
	localparam int CFG_ADDR_W     = 6;

	localparam logic [RES_W-1:0] RES_FULL = '1;

	typedef enum logic [2:0] {
		REG_WARP_ROW0  = 3'd0,
		REG_WARP_ROW1  = 3'd1,
		REG_WARP_ROW2  = 3'd2,
		REG_MASK_ROW0  = 3'd3,
		REG_MASK_ROW1  = 3'd4,
		REG_MASK_ROW2  = 3'd5,
		REG_OUT_WIDTH  = 3'd6,
		REG_OUT_HEIGHT = 3'd7
	} reg_idx_t;

	typedef logic signed [ACC_W-1:0] acc_t;
	typedef logic [ROW_W-1:0]        row_t;
	typedef logic [DIM_W-1:0]        dim_t;

	// Extract signed coefficient of a column from a packed row.
	function automatic logic signed [COEF_BITS-1:0] coef_of(input row_t row,
			input logic [1:0] col);
		logic [COEF_BITS-1:0] f;
		f = row[col*COEF_BITS +: COEF_BITS];
		return $signed(f);
	endfunction

	// Clamp a table size to 2..MAX_DIM and subtract one.
	function automatic logic [PIX_W-1:0] dim_m1(input dim_t d);
		dim_t c;
		c = d;
		if (d < dim_t'(2)) begin
			c = dim_t'(2);
		end
		if (d > dim_t'(MAX_DIM)) begin
			c = dim_t'(MAX_DIM);
		end
		return PIX_W'(c - dim_t'(1));
	endfunction

endpackage

// ===== rtl/hwl_scale16.sv =====
// ============================================================================
// hwl_scale16: pipelined saturating n*65535/d
// One entry stage, then one restoring quotient bit per stage.
// ============================================================================
module hwl_scale16 (
	input  logic                   clk,
	input  logic                   en,
	input  hwl_pkg::acc_t          num,
	input  hwl_pkg::acc_t          den,   // positive
	output logic [hwl_pkg::RES_W-1:0] res
);
	import hwl_pkg::*;

	localparam int R_W = ACC_W + 1;

	logic [R_W-1:0]   r_s   [DIV_STEPS+1];
	logic [ACC_W-1:0] d_s   [DIV_STEPS+1];
	logic [ACC_W-1:0] n_s   [DIV_STEPS+1];
	logic [RES_W-1:0] q_s   [DIV_STEPS+1];
	logic             zero_s[DIV_STEPS+1];
	logic             full_s[DIV_STEPS+1];

	// entry: classify the saturating cases
	always_ff @(posedge clk) begin
		if (en) begin
			r_s[0]    <= R_W'(unsigned'(num));
			n_s[0]    <= num;
			d_s[0]    <= den;
			q_s[0]    <= '0;
			zero_s[0] <= (num <= acc_t'(0));
			full_s[0] <= (num >= den);
		end
	end

	for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
		logic [R_W-1:0] r2;
		logic           take;
		assign r2   = {r_s[k][R_W-2:0], 1'b0};
		assign take = (r2 >= {1'b0, d_s[k]});
		always_ff @(posedge clk) begin
			if (en) begin
				r_s[k+1]    <= take ? (r2 - {1'b0, d_s[k]}) : r2;
				q_s[k+1]    <= {q_s[k][RES_W-2:0], take};
				n_s[k+1]    <= n_s[k];
				d_s[k+1]    <= d_s[k];
				zero_s[k+1] <= zero_s[k];
				full_s[k+1] <= full_s[k];
			end
		end
	end

	// 65535 n = q d + r - n: one less when the remainder is short of n
	always_comb begin
		if (zero_s[DIV_STEPS]) begin
			res = '0;
		end else if (full_s[DIV_STEPS]) begin
			res = RES_FULL;
		end else if (r_s[DIV_STEPS] < R_W'(n_s[DIV_STEPS])) begin
			res = q_s[DIV_STEPS] - RES_W'(1);
		end else begin
			res = q_s[DIV_STEPS];
		end
	end

endmodule

// ===== rtl/homography_warp_lut_pixel.sv =====
// ============================================================================
// homography_warp_lut_pixel: perspective warp lookup, one pixel per clock unless held
// Normalizes a pixel, maps it through warp and mask homographies, and
// returns the coverage mask and the warped source coordinate in 0..65535.
// ============================================================================
// Pipeline: 4 arithmetic stages, 17 divider stages, one output register.
// Throughput: one pixel per clock; the whole pipe stalls only while a
//   result sits in the output register and m_axis_tready is low.
// Reset: valid bits clear, matrices reset to zero, sizes to 1024.
// ============================================================================
module homography_warp_lut_pixel (
	input  logic        clk,
	input  logic        arst_n,
	// input pixel stream
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,   // pixel_x[11:0], pixel_y[23:12]
	// result stream
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [47:0] m_axis_tdata,   // coverage_mask[15:0], src_u[31:16], src_v[47:32]
	// register port
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [hwl_pkg::CFG_ADDR_W-1:0]  paddr,
	input  logic [hwl_pkg::CFG_DATA_W-1:0]  pwdata,
	output logic [hwl_pkg::CFG_DATA_W-1:0]  prdata,
	output logic                            pready
);
	import hwl_pkg::*;

	localparam int DIV_LAT = DIV_STEPS + 1;

	// ---------------- configuration registers ----------------
	row_t     row_q [2][3];   // [matrix: 0 warp, 1 mask][row]
	dim_t     width_q, height_q;
	reg_idx_t widx;
	logic     wr;

	assign pready = 1'b1;
	assign widx   = reg_idx_t'(paddr[5:3]);
	assign wr     = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int m = 0; m < 2; m++) begin
				for (int r = 0; r < 3; r++) begin
					row_q[m][r] <= '0;
				end
			end
			width_q  <= dim_t'(1024);
			height_q <= dim_t'(1024);
		end else if (wr) begin
			case (widx)
				REG_WARP_ROW0:  row_q[0][0] <= pwdata[ROW_W-1:0];
				REG_WARP_ROW1:  row_q[0][1] <= pwdata[ROW_W-1:0];
				REG_WARP_ROW2:  row_q[0][2] <= pwdata[ROW_W-1:0];
				REG_MASK_ROW0:  row_q[1][0] <= pwdata[ROW_W-1:0];
				REG_MASK_ROW1:  row_q[1][1] <= pwdata[ROW_W-1:0];
				REG_MASK_ROW2:  row_q[1][2] <= pwdata[ROW_W-1:0];
				REG_OUT_WIDTH:  width_q     <= pwdata[DIM_W-1:0];
				REG_OUT_HEIGHT: height_q    <= pwdata[DIM_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (widx)
			REG_WARP_ROW0:  prdata = CFG_DATA_W'(row_q[0][0]);
			REG_WARP_ROW1:  prdata = CFG_DATA_W'(row_q[0][1]);
			REG_WARP_ROW2:  prdata = CFG_DATA_W'(row_q[0][2]);
			REG_MASK_ROW0:  prdata = CFG_DATA_W'(row_q[1][0]);
			REG_MASK_ROW1:  prdata = CFG_DATA_W'(row_q[1][1]);
			REG_MASK_ROW2:  prdata = CFG_DATA_W'(row_q[1][2]);
			REG_OUT_WIDTH:  prdata = CFG_DATA_W'(width_q);
			REG_OUT_HEIGHT: prdata = CFG_DATA_W'(height_q);
			default:        prdata = '0;
		endcase
	end

	// ---------------- pipeline control ----------------
	// Single advance enable: everything moves unless the output is held.
	logic en;
	logic v_s1, v_s2, v_s3, v_s4;
	logic vdiv_q [DIV_LAT];
	logic out_vld_q;

	assign en            = ~out_vld_q | m_axis_tready;
	assign s_axis_tready = en;
	assign m_axis_tvalid = out_vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			for (int k = 0; k < DIV_LAT; k++) begin
				vdiv_q[k] <= 1'b0;
			end
			out_vld_q <= 1'b0;
		end else if (en) begin
			v_s1      <= s_axis_tvalid;
			v_s2      <= v_s1;
			v_s3      <= v_s2;
			v_s4      <= v_s3;
			vdiv_q[0] <= v_s4;
			for (int k = 1; k < DIV_LAT; k++) begin
				vdiv_q[k] <= vdiv_q[k-1];
			end
			out_vld_q <= vdiv_q[DIV_LAT-1];
		end
	end

	// ---------------- stage 1: normalization products ----------------
	// Common denominator (W-1)(H-1): x term px*(H-1), y term py*(W-1).
	logic [PIX_W-1:0]  wm1, hm1;
	logic [PROD_W-1:0] xa_s1, ya_s1, wh_s1;

	assign wm1 = dim_m1(width_q);
	assign hm1 = dim_m1(height_q);

	always_ff @(posedge clk) begin
		if (en) begin
			xa_s1 <= s_axis_tdata[11:0] * hm1;
			ya_s1 <= s_axis_tdata[23:12] * wm1;
			wh_s1 <= wm1 * hm1;
		end
	end

	// ---------------- stage 2: coefficient products ----------------
	acc_t              p_s2 [2][3][3];
	logic [PROD_W-1:0] wh_s2, wh_s3;
	logic [PROD_W-1:0] opnd [3];

	assign opnd[0] = xa_s1;
	assign opnd[1] = ya_s1;
	assign opnd[2] = wh_s1;

	// 21 x 25 bit signed products, operands sign-extended to the full width
	always_ff @(posedge clk) begin
		if (en) begin
			for (int m = 0; m < 2; m++) begin
				for (int r = 0; r < 3; r++) begin
					for (int c = 0; c < 3; c++) begin
						p_s2[m][r][c] <= acc_t'(coef_of(row_q[m][r], 2'(c)))
							* acc_t'($signed({1'b0, opnd[c]}));
					end
				end
			end
			wh_s2 <= wh_s1;
		end
	end

	// ---------------- stage 3: homogeneous components ----------------
	acc_t comp_s3 [2][3];

	always_ff @(posedge clk) begin
		if (en) begin
			for (int m = 0; m < 2; m++) begin
				for (int r = 0; r < 3; r++) begin
					comp_s3[m][r] <= p_s2[m][r][0] + p_s2[m][r][1] + p_s2[m][r][2];
				end
			end
			wh_s3 <= wh_s2;
		end
	end

	// ---------------- stage 4: denominator select, sign fold ----------------
	// Zero third component falls back to the plain normalization scale.
	acc_t nx_s4 [2], ny_s4 [2], d_s4 [2];

	always_ff @(posedge clk) begin
		if (en) begin
			for (int m = 0; m < 2; m++) begin
				acc_t d;
				d = (comp_s3[m][2] != acc_t'(0)) ? comp_s3[m][2]
					: acc_t'({wh_s3, {COEF_FRAC_BITS{1'b0}}});
				if (d < acc_t'(0)) begin
					d_s4[m]  <= -d;
					nx_s4[m] <= -comp_s3[m][0];
					ny_s4[m] <= -comp_s3[m][1];
				end else begin
					d_s4[m]  <= d;
					nx_s4[m] <= comp_s3[m][0];
					ny_s4[m] <= comp_s3[m][1];
				end
			end
		end
	end

	// ---------------- coverage test, delayed alongside the divider ----------------
	logic covered;
	logic in_q [DIV_LAT];

	always_comb begin
		covered = 1'b1;
		for (int m = 0; m < 2; m++) begin
			covered &= (nx_s4[m] >= acc_t'(0)) && (nx_s4[m] <= d_s4[m])
				&& (ny_s4[m] >= acc_t'(0)) && (ny_s4[m] <= d_s4[m]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			in_q[0] <= covered;
			for (int k = 1; k < DIV_LAT; k++) begin
				in_q[k] <= in_q[k-1];
			end
		end
	end

	// ---------------- warped coordinate scaling ----------------
	logic [RES_W-1:0] u_res, v_res;

	hwl_scale16 u_scale_u (
		.clk (clk),
		.en  (en),
		.num (nx_s4[0]),
		.den (d_s4[0]),
		.res (u_res)
	);

	hwl_scale16 u_scale_v (
		.clk (clk),
		.en  (en),
		.num (ny_s4[0]),
		.den (d_s4[0]),
		.res (v_res)
	);

	// ---------------- output register ----------------
	logic [RES_W-1:0] mask_q, u_q, v_q;

	always_ff @(posedge clk) begin
		if (en) begin
			mask_q <= in_q[DIV_LAT-1] ? RES_FULL : '0;
			u_q    <= u_res;
			v_q    <= v_res;
		end
	end

	assign m_axis_tdata = {v_q, u_q, mask_q};

	// ---------------- assertions ----------------
	a_mask_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (mask_q == '0 || mask_q == RES_FULL))
		else $error("coverage mask not all-zero or all-one");

	a_den_pos: assert property (@(posedge clk) disable iff (!arst_n)
		v_s4 |-> (d_s4[0] > acc_t'(0) && d_s4[1] > acc_t'(0)))
		else $error("denominator not positive");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> ($stable(v_s4) && $stable(vdiv_q[0]) && $stable(out_vld_q)))
		else $error("pipeline moved during stall");

endmodule

// ===== tb/homography_warp_lut_pixel_tb.sv =====
// ============================================================================
// homography_warp_lut_pixel_tb: self-checking bench for the warp lookup
// Programs warp/mask matrices and table sizes over APB, streams pixels with
// random gaps and back-pressure, and checks every result against a directed
// value or a local exact-integer model of the normalize/map/divide/scale path.
// ============================================================================
module homography_warp_lut_pixel_tb;
	import hwl_pkg::*;

	typedef struct packed {
		logic [RES_W-1:0] mask;
		logic [RES_W-1:0] u;
		logic [RES_W-1:0] v;
	} lut_res_t;

	// directed stimulus row; want is used only where the result is obvious
	typedef struct {
		logic [PIX_W-1:0] x;
		logic [PIX_W-1:0] y;
		bit               known;
		lut_res_t         want;
	} pix_row_t;

	logic                  clk;
	logic                  arst_n;
	logic                  s_axis_tvalid;
	logic                  s_axis_tready;
	logic [23:0]           s_axis_tdata;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready;
	logic [47:0]           m_axis_tdata;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [CFG_ADDR_W-1:0] paddr;
	logic [CFG_DATA_W-1:0] pwdata;
	logic [CFG_DATA_W-1:0] prdata;
	logic                  pready;

	// local copy of the register file
	row_t     warp_m [3];
	row_t     mask_m [3];
	dim_t     tbl_w;
	dim_t     tbl_h;

	lut_res_t pending_px [$];
	int       errors;
	int       results_seen;
	bit       hold_off_done;

	homography_warp_lut_pixel i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),   // pixel_x[11:0], pixel_y[23:12]
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),   // coverage_mask[15:0], src_u[31:16], src_v[47:32]
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// --------------------------------------------------------------------------
	// Exact-integer warp model
	// --------------------------------------------------------------------------
	function automatic longint coef_at(row_t r, int col);
		logic signed [COEF_BITS-1:0] f;
		f = r[col*COEF_BITS +: COEF_BITS];
		return longint'(f);
	endfunction

	function automatic longint clamp_size(dim_t d);
		if (d < 2) begin
			return 2;
		end
		if (d > MAX_DIM) begin
			return MAX_DIM;
		end
		return longint'(d);
	endfunction

	// numerators over a positive common denominator
	function automatic void map_homog(input row_t m [3], input longint px, py, wm1, hm1,
			output longint nx, ny, dn);
		longint comp [3];
		for (int i = 0; i < 3; i++) begin
			comp[i] = coef_at(m[i], 0) * px * hm1 + coef_at(m[i], 1) * py * wm1
				+ coef_at(m[i], 2) * wm1 * hm1;
		end
		// zero third component: no perspective divide
		dn = (comp[2] != 0) ? comp[2] : wm1 * hm1 * (longint'(1) << COEF_FRAC_BITS);
		nx = comp[0];
		ny = comp[1];
		if (dn < 0) begin
			dn = -dn;
			nx = -nx;
			ny = -ny;
		end
	endfunction

	// floor(n * 65535 / d), saturated
	function automatic logic [RES_W-1:0] scale_sat(longint n, longint d);
		logic [63:0] r;
		logic [63:0] q;
		if (n <= 0) begin
			return '0;
		end
		if (n >= d) begin
			return RES_FULL;
		end
		r = n;
		q = 0;
		for (int i = 0; i < 16; i++) begin
			r = r << 1;
			q = q << 1;
			if (r >= d) begin
				r = r - d;
				q[0] = 1'b1;
			end
		end
		if (r < n) begin
			q = q - 1;
		end
		return q[RES_W-1:0];
	endfunction

	function automatic lut_res_t warp_lookup(logic [PIX_W-1:0] x, logic [PIX_W-1:0] y);
		longint   wm1, hm1, wx, wy, wd, mx, my, md;
		lut_res_t r;
		wm1 = clamp_size(tbl_w) - 1;
		hm1 = clamp_size(tbl_h) - 1;
		map_homog(warp_m, x, y, wm1, hm1, wx, wy, wd);
		map_homog(mask_m, x, y, wm1, hm1, mx, my, md);
		r.mask = (mx >= 0 && mx <= md && my >= 0 && my <= md
			&& wx >= 0 && wx <= wd && wy >= 0 && wy <= wd) ? RES_FULL : '0;
		r.u = scale_sat(wx, wd);
		r.v = scale_sat(wy, wd);
		return r;
	endfunction

	// --------------------------------------------------------------------------
	// Register port
	// --------------------------------------------------------------------------
	task automatic reg_write(reg_idx_t idx, logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		psel    <= 1'b1;
		pwrite  <= 1'b1;
		penable <= 1'b0;
		paddr   <= CFG_ADDR_W'(idx) << 3;
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		case (idx)
			REG_WARP_ROW0, REG_WARP_ROW1, REG_WARP_ROW2: warp_m[int'(idx)] = val[ROW_W-1:0];
			REG_MASK_ROW0, REG_MASK_ROW1, REG_MASK_ROW2: mask_m[int'(idx) - 3] = val[ROW_W-1:0];
			REG_OUT_WIDTH:  tbl_w = val[DIM_W-1:0];
			default:        tbl_h = val[DIM_W-1:0];
		endcase
	endtask

	// wait for the pipe to drain before touching registers
	task automatic drain();
		while (pending_px.size() != 0) begin
			@(posedge clk);
		end
		repeat (30) @(posedge clk);
	endtask

	function automatic row_t pack_row(int c0, int c1, int c2);
		return {COEF_BITS'(c2), COEF_BITS'(c1), COEF_BITS'(c0)};
	endfunction

	function automatic int jitter(int span);
		return int'($urandom_range(0, 2 * span)) - span;
	endfunction

	// one matrix: near identity, near identity with zero last row, or raw bits
	task automatic rand_matrix(bit is_mask, int mode);
		row_t r [3];
		int   sp;
		sp = 1 << $urandom_range(4, 14);
		for (int i = 0; i < 3; i++) begin
			if (mode == 2) begin
				r[i] = row_t'({$urandom, $urandom});
			end else if (i == 2 && mode == 1) begin
				r[i] = '0;
			end else begin
				r[i] = pack_row((i == 0 ? 65536 : 0) + jitter(sp),
					(i == 1 ? 65536 : 0) + jitter(sp),
					(i == 2 ? 65536 : 0) + jitter(sp));
			end
		end
		for (int i = 0; i < 3; i++) begin
			reg_write(reg_idx_t'(i + (is_mask ? 3 : 0)), {1'b0, r[i]});
		end
	endtask

	function automatic dim_t rand_size();
		case ($urandom_range(0, 5))
			0:       return dim_t'(2);
			1:       return dim_t'(MAX_DIM);
			2:       return dim_t'($urandom_range(0, 8191));   // exercises clamping
			default: return dim_t'($urandom_range(2, 64));
		endcase
	endfunction

	// --------------------------------------------------------------------------
	// Pixel sender
	// --------------------------------------------------------------------------
	task automatic send_pixel(logic [PIX_W-1:0] x, logic [PIX_W-1:0] y, bit known,
			lut_res_t want);
		int gap;
		gap = $urandom_range(0, 7);
		if ($urandom_range(0, 3) == 0) begin
			gap = 0;   // back-to-back stretches
		end
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {y, x};
		do @(negedge clk); while (!s_axis_tready);
		@(posedge clk);
		pending_px = {pending_px, (known ? want : warp_lookup(x, y))};
	endtask

	// valid drops right after the last transfer edge
	task automatic walk_table(const ref pix_row_t t [], input bit use_known);
		foreach (t[i]) begin
			send_pixel(t[i].x, t[i].y, use_known && t[i].known, t[i].want);
		end
		s_axis_tvalid <= 1'b0;
	endtask

	function automatic logic [PIX_W-1:0] rand_pix(dim_t d);
		longint lim;
		lim = clamp_size(d);
		if ($urandom_range(0, 9) == 0) begin
			return PIX_W'($urandom);   // anywhere, may lie outside the table
		end
		return PIX_W'($urandom_range(0, lim - 1));
	endfunction

	// --------------------------------------------------------------------------
	// Result receiver with random stalls and one long hold-off
	// --------------------------------------------------------------------------
	initial begin
		int       stall;
		lut_res_t got;
		lut_res_t exp_r;
		m_axis_tready = 1'b0;
		hold_off_done = 1'b0;
		results_seen  = 0;
		@(posedge arst_n);
		forever begin
			stall = $urandom_range(0, 7);
			if ($urandom_range(0, 3) == 0) begin
				stall = 0;
			end
			if (!hold_off_done && results_seen == 400) begin
				stall = 300;   // let the pipe fill and push back on the input
				hold_off_done = 1'b1;
			end
			if (stall > 0) begin
				m_axis_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(negedge clk); while (!m_axis_tvalid);
			got = {m_axis_tdata[15:0], m_axis_tdata[31:16], m_axis_tdata[47:32]};
			@(posedge clk);
			results_seen++;
			if (pending_px.size() == 0) begin
				$error("unexpected result transfer: %h", m_axis_tdata);
				errors++;
			end else begin
				exp_r = pending_px.pop_front();
				if (got.mask !== exp_r.mask) begin
					$error("coverage_mask: expected %0d, got %0d", exp_r.mask, got.mask);
					errors++;
				end
				if (got.u !== exp_r.u) begin
					$error("src_u: expected %0d, got %0d", exp_r.u, got.u);
					errors++;
				end
				if (got.v !== exp_r.v) begin
					$error("src_v: expected %0d, got %0d", exp_r.v, got.v);
					errors++;
				end
			end
		end
	end

	// --------------------------------------------------------------------------
	// Main sequence
	// --------------------------------------------------------------------------
	initial begin
		pix_row_t dir_tab [];
		// zero matrices: third component zero, so every pixel maps to (0,0)
		dir_tab = '{
			'{12'd0,    12'd0,    1'b1, '{RES_FULL, 16'd0, 16'd0}},
			'{12'd1023, 12'd1023, 1'b1, '{RES_FULL, 16'd0, 16'd0}},
			'{12'd4095, 12'd0,    1'b1, '{RES_FULL, 16'd0, 16'd0}},
			'{12'd0,    12'd4095, 1'b1, '{RES_FULL, 16'd0, 16'd0}},
			'{12'd4095, 12'd4095, 1'b1, '{RES_FULL, 16'd0, 16'd0}},
			'{12'd511,  12'd512,  1'b1, '{RES_FULL, 16'd0, 16'd0}},
			'{12'd1,    12'd1,    1'b0, '{default: '0}},
			'{12'hAAA,  12'h555,  1'b0, '{default: '0}},
			'{12'h555,  12'hAAA,  1'b0, '{default: '0}},
			'{12'd1024, 12'd3,    1'b0, '{default: '0}},
			'{12'd2,    12'd2048, 1'b0, '{default: '0}}
		};
		errors        = 0;
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		psel          = 1'b0;
		penable       = 1'b0;
		pwrite        = 1'b0;
		paddr         = '0;
		pwdata        = '0;
		foreach (warp_m[i]) begin
			warp_m[i] = '0;
			mask_m[i] = '0;
		end
		tbl_w = dim_t'(1024);
		tbl_h = dim_t'(1024);
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		walk_table(dir_tab, 1'b1);
		drain();

		// identity warp, shifted mask; width below two and height beyond max
		reg_write(REG_WARP_ROW0, {1'b0, pack_row(65536, 0, 0)});
		reg_write(REG_WARP_ROW1, {1'b0, pack_row(0, 65536, 0)});
		reg_write(REG_WARP_ROW2, {1'b0, pack_row(0, 0, 65536)});
		reg_write(REG_MASK_ROW0, {1'b0, pack_row(-1048576, 1048575, 0)});
		reg_write(REG_MASK_ROW1, {1'b0, pack_row(0, 65536, -32768)});
		reg_write(REG_MASK_ROW2, {1'b0, pack_row(0, 0, -65536)});   // negative divisor
		reg_write(REG_OUT_WIDTH,  64'd1);
		reg_write(REG_OUT_HEIGHT, 64'd8191);
		walk_table(dir_tab, 1'b0);
		drain();
		reg_write(REG_OUT_WIDTH,  64'd4096);
		reg_write(REG_OUT_HEIGHT, 64'd2);
		walk_table(dir_tab, 1'b0);
		drain();

		// random phases, each with a fresh configuration
		for (int ph = 0; ph < 9; ph++) begin
			rand_matrix(1'b0, (ph % 4 == 3) ? 2 : (ph % 3 == 1) ? 1 : 0);
			rand_matrix(1'b1, (ph % 5 == 4) ? 2 : 0);
			reg_write(REG_OUT_WIDTH,  {51'd0, rand_size()});
			reg_write(REG_OUT_HEIGHT, {51'd0, rand_size()});
			for (int k = 0; k < 200; k++) begin
				send_pixel(rand_pix(tbl_w), rand_pix(tbl_h), 1'b0, '0);
			end
			s_axis_tvalid <= 1'b0;
			drain();
		end

		if (errors == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

	initial begin
		#2000000;
		$display("== FAIL ==");
		$finish;
	end

endmodule
